// ===== rtl/shutter_travel_position_tracker_macros.svh =====
// Assertion macros used by the shutter travel tracker datapath.
`ifndef SHUTTER_TRAVEL_POSITION_TRACKER_MACROS_SVH
`define SHUTTER_TRAVEL_POSITION_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define STP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shutter tracker assertion failed");

// Next-cycle implication, disabled while reset is low.
`define STP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shutter tracker assertion failed");

`endif

// ===== rtl/stp_pkg.sv =====
// Types and constants for the shutter travel position tracker.
package stp_pkg;

    localparam int TIME_W  = 32;
    localparam int POS_W   = 7;
    localparam int POWER_W = 16;
    localparam int FULL_W  = 8;
    localparam int DIV_W   = 12;
    localparam int SPAN_W  = 19;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_RAISE = 3'd1;
    localparam logic [2:0] CMD_LOWER = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_GOTO  = 3'd4;

    localparam logic [1:0] DIR_STOPPED = 2'd0;
    localparam logic [1:0] DIR_OPENING = 2'd1;
    localparam logic [1:0] DIR_CLOSING = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNCAL   = 2'd1;
    localparam logic [1:0] ERR_RANGE   = 2'd2;

    localparam logic [1:0] REG_CALIBRATED  = 2'd0;
    localparam logic [1:0] REG_FULL_TRAVEL = 2'd1;
    localparam logic [1:0] REG_IDLE_POWER  = 2'd2;

    localparam logic [TIME_W-1:0] END_STOP_EXTRA_MS = 32'd2000;
    localparam logic [TIME_W-1:0] UNCAL_TRAVEL_MS   = 32'd100000;
    localparam logic [TIME_W-1:0] POWER_GRACE_MS    = 32'd2000;
    localparam logic [POS_W-1:0]  FULL_POSITION     = 7'd100;
    localparam logic [POS_W-1:0]  RESET_POSITION    = 7'd50;
    localparam logic [FULL_W-1:0] RESET_FULL_TRAVEL = 8'd20;
    localparam logic [POWER_W-1:0] RESET_IDLE_POWER = 16'd50;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_HALT,
        S_SPAN,
        S_START,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               calibrated;
        logic [FULL_W-1:0]  full_s;
        logic [POWER_W-1:0] idle_thr;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic div_start;
        logic halt;
        logic span;
        logic start;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic halt_req;
        logic div_done;
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== rtl/shutter_travel_position_tracker.sv =====
// Top level of the roller shutter travel position tracker.
//
//  channel   | direction | handshake                | payload
//  s_axis    | in        | s_axis_tvalid/tready     | tdata target,now,power; tuser command
//  m_axis    | out       | m_axis_tvalid/tready     | tdata relays,position,state,error
//  apb       | in        | psel/penable/pwrite      | paddr, pwdata, prdata
//
// One transaction at a time; a transaction that stops a travel also runs the
// 32-step divider that turns elapsed time into percent.
// Reset is synchronous and active low; position 50, stopped, registers at defaults.
// A finished result waits in the output register while the next item is taken;
// the controller stalls before loading a new result until the old one leaves.
module shutter_travel_position_tracker
    import stp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // target_position[6:0], now_ms[38:7], motor_power[54:39]
    input  logic [2:0]  s_axis_tuser,  // command[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // relay_up[0], relay_down[1], position[8:2],
                                       // travel_state[10:9], error_code[12:11]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.calibrated <= 1'b0;
            r_cfg.full_s     <= RESET_FULL_TRAVEL;
            r_cfg.idle_thr   <= RESET_IDLE_POWER;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_CALIBRATED:  r_cfg.calibrated <= pwdata[0];
                REG_FULL_TRAVEL: r_cfg.full_s     <= pwdata[FULL_W-1:0];
                REG_IDLE_POWER:  r_cfg.idle_thr   <= pwdata[POWER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CALIBRATED:  prdata = {31'b0, r_cfg.calibrated};
            REG_FULL_TRAVEL: prdata = {24'b0, r_cfg.full_s};
            REG_IDLE_POWER:  prdata = {16'b0, r_cfg.idle_thr};
            default:         prdata = '0;
        endcase
    end

    stp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    stp_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_command  (s_axis_tuser),
        .i_target   (s_axis_tdata[6:0]),
        .i_now      (s_axis_tdata[38:7]),
        .i_power    (s_axis_tdata[54:39]),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

// ===== rtl/stp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module stp_div
    import stp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [TIME_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(TIME_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dvs;

    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_sub;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[TIME_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_sub   = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(TIME_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TIME_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DIV_W-1:0] : w_trial[DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/stp_datapath.sv =====
// Datapath: travel state, position update, deadline arithmetic and result register.
`include "shutter_travel_position_tracker_macros.svh"

module stp_datapath
    import stp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [2:0]         i_command,
    input  logic [POS_W-1:0]   i_target,
    input  logic [TIME_W-1:0]  i_now,
    input  logic [POWER_W-1:0] i_power,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic [15:0]        o_m_tdata
);

    logic [2:0]         r_command;
    logic [POS_W-1:0]   r_target;
    logic [TIME_W-1:0]  r_now;
    logic [POWER_W-1:0] r_power;

    logic [POS_W-1:0]   r_pos,      n_pos;
    logic [1:0]         r_dir,      n_dir;
    logic [TIME_W-1:0]  r_start,    n_start;
    logic [TIME_W-1:0]  r_deadline, n_deadline;

    logic [SPAN_W-1:0]  r_span,   n_span;
    logic [1:0]         r_sdir,   n_sdir;
    logic               r_send,   n_send;
    logic               r_sbegin, n_sbegin;

    logic               r_out_valid;
    logic               r_relay_up;
    logic               r_relay_down;
    logic [POS_W-1:0]   r_out_pos;
    logic [1:0]         r_out_state;
    logic [1:0]         r_out_err;

    logic [FULL_W-1:0]  w_full;
    logic [DIV_W-1:0]   w_div;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_moving;
    logic               w_goto_ok;
    logic               w_halt_req;
    logic               w_div_done;
    logic [TIME_W-1:0]  w_quo;
    logic [POS_W-1:0]   w_room;
    logic [POS_W-1:0]   w_tgt;
    logic [POS_W-1:0]   w_dist;
    logic [TIME_W-1:0]  w_offset;
    logic [1:0]         w_err;

    assign w_full    = (i_cfg.full_s == '0) ? FULL_W'(1) : i_cfg.full_s;
    assign w_div     = (DIV_W'(w_full) << 3) + (DIV_W'(w_full) << 1);
    assign w_elapsed = r_now - r_start;
    assign w_moving  = r_dir != DIR_STOPPED;
    assign w_goto_ok = i_cfg.calibrated && (r_target <= FULL_POSITION);
    assign w_room    = FULL_POSITION - r_pos;

    stp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_elapsed),
        .i_divisor  (w_div),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        unique case (r_command)
            CMD_TICK: begin
                w_halt_req = w_moving && ((r_now > r_deadline) ||
                             ((w_elapsed > POWER_GRACE_MS) && (r_power < i_cfg.idle_thr)));
            end
            CMD_RAISE, CMD_LOWER, CMD_STOP: w_halt_req = w_moving;
            CMD_GOTO: w_halt_req = w_moving && w_goto_ok;
            default:  w_halt_req = 1'b0;
        endcase
    end

    always_comb begin
        if (r_command != CMD_GOTO) begin
            w_err = ERR_NONE;
        end else if (!i_cfg.calibrated) begin
            w_err = ERR_UNCAL;
        end else if (r_target > FULL_POSITION) begin
            w_err = ERR_RANGE;
        end else begin
            w_err = ERR_NONE;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_dir      = r_dir;
        n_start    = r_start;
        n_deadline = r_deadline;
        n_span     = r_span;
        n_sdir     = r_sdir;
        n_send     = r_send;
        n_sbegin   = r_sbegin;
        w_tgt      = r_target;
        w_dist     = '0;
        w_offset   = UNCAL_TRAVEL_MS;

        if (i_cmd.halt) begin
            if (i_cfg.calibrated && (r_dir == DIR_OPENING)) begin
                n_pos = (w_quo >= TIME_W'(w_room)) ? FULL_POSITION : r_pos + w_quo[POS_W-1:0];
            end else if (i_cfg.calibrated && (r_dir == DIR_CLOSING)) begin
                n_pos = (w_quo >= TIME_W'(r_pos)) ? '0 : r_pos - w_quo[POS_W-1:0];
            end else begin
                n_pos = RESET_POSITION;
            end
            n_dir = DIR_STOPPED;
        end

        if (i_cmd.span) begin
            unique case (r_command)
                CMD_RAISE: begin
                    w_tgt    = FULL_POSITION;
                    n_sdir   = DIR_OPENING;
                    n_sbegin = 1'b1;
                end
                CMD_LOWER: begin
                    w_tgt    = '0;
                    n_sdir   = DIR_CLOSING;
                    n_sbegin = 1'b1;
                end
                CMD_GOTO: begin
                    w_tgt    = r_target;
                    n_sdir   = (r_target > r_pos) ? DIR_OPENING : DIR_CLOSING;
                    n_sbegin = w_goto_ok && (r_target != r_pos);
                end
                default: begin
                    n_sdir   = DIR_STOPPED;
                    n_sbegin = 1'b0;
                end
            endcase
            w_dist = (n_sdir == DIR_OPENING) ? w_tgt - r_pos : r_pos - w_tgt;
            n_span = SPAN_W'(w_div) * SPAN_W'(w_dist);
            n_send = ((n_sdir == DIR_OPENING) && (w_tgt == FULL_POSITION)) ||
                     ((n_sdir == DIR_CLOSING) && (w_tgt == '0));
        end

        if (i_cmd.start && r_sbegin) begin
            if (i_cfg.calibrated) begin
                w_offset = TIME_W'(r_span) + (r_send ? END_STOP_EXTRA_MS : '0);
            end
            n_start    = r_now;
            n_deadline = r_now + w_offset;
            n_dir      = r_sdir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= RESET_POSITION;
            r_dir       <= DIR_STOPPED;
            r_start     <= '0;
            r_deadline  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_dir      <= n_dir;
            r_start    <= n_start;
            r_deadline <= n_deadline;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_span   <= n_span;
        r_sdir   <= n_sdir;
        r_send   <= n_send;
        r_sbegin <= n_sbegin;
        if (i_cmd.load) begin
            r_command <= i_command;
            r_target  <= i_target;
            r_now     <= i_now;
            r_power   <= i_power;
        end
        if (i_cmd.out_load) begin
            r_relay_up   <= r_dir == DIR_OPENING;
            r_relay_down <= r_dir == DIR_CLOSING;
            r_out_pos    <= r_pos;
            r_out_state  <= r_dir;
            r_out_err    <= w_err;
        end
    end

    assign o_sts.halt_req = w_halt_req;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_busy = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_err, r_out_state, r_out_pos, r_relay_down, r_relay_up};

    `STP_ASSERT_IMP(a_relays_exclusive, i_clk, i_rst_n, r_out_valid, !(r_relay_up && r_relay_down))
    `STP_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, 1'b1, r_pos <= FULL_POSITION)
    `STP_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, i_cmd.out_load, !o_sts.out_busy)
    `STP_ASSERT_NXT(a_halt_stops, i_clk, i_rst_n, i_cmd.halt, r_dir == DIR_STOPPED)

endmodule

// ===== rtl/stp_ctrl.sv =====
// Controller: sequences one transaction through the datapath.
module stp_ctrl
    import stp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.halt_req) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_SPAN;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_HALT;
                end
            end
            S_HALT: begin
                o_cmd.halt = 1'b1;
                n_state    = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_state    = S_START;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
